// ===== hw/rtl/dafp_pkg.sv =====
// dafp_pkg: constants and the arctangent table for the dihedral angle pipeline
// no dependencies; used by dihedral_angle_four_points_top
`timescale 1ns / 1ps
`default_nettype none

package dafp_pkg;

	// scaled vectors: largest magnitude in [2^13, 2^14)
	localparam int VEC_TOP = 14;
	localparam int VEC_W = VEC_TOP + 1;
	localparam int PROD_W = 2 * VEC_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int CROSS_W = PROD_W + 1;
	localparam int TRIP_W = CROSS_W + VEC_W + 2;

	// floor square root of the scaled squared axis length
	localparam int ROOT_W = VEC_TOP + 1;
	localparam int REM_W = 2 * ROOT_W + 2;
	localparam int ISQ_PER = 3;
	localparam int ISQ_ST = (ROOT_W + ISQ_PER - 1) / ISQ_PER;

	// atan2 terms: larger magnitude scaled into [2^28, 2^29)
	localparam int TERM_W = 64;
	localparam int TERM_TOP = 29;
	localparam int TSH_W = 7;

	// vectoring rotation, angle in units of 2^32 per turn
	localparam int CORDIC_STEPS = 30;
	localparam int XY_W = TERM_TOP + 5;
	localparam int Z_W = 34;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
		32'd20860, 32'd10430, 32'd5215, 32'd2607, 32'd1303,
		32'd651, 32'd325, 32'd162, 32'd81, 32'd40,
		32'd20, 32'd10, 32'd5, 32'd2, 32'd1
	};

endpackage

`default_nettype wire

// ===== hw/rtl/dihedral_angle_four_points_top.sv =====
// dihedral_angle_four_points_top: pipelined torsion angle of four points
// depends on dafp_pkg (widths, table of arctangent steps)
//
//   channel   handshake        payload
//   input     start / busy     ax ay az bx by bz cx cy cz dx dy dz
//   result    done (strobe)    torsion degenerate
//
// one quadruple is taken every cycle; busy is always low
// pipeline stages: vector normalise (4), products and sums (2), square root
// (5 stages, 3 bits each), term product, term normalise (3), 31 rotation stages, rounding
// the rotation chain of one add per stage sets the depth
// reset clears only the valid bits; results appear for one cycle with done high
`timescale 1ns / 1ps
`default_nettype none

module dihedral_angle_four_points_top #(
	parameter int COORD_BITS = 20,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] az,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	input  wire logic signed [COORD_BITS-1:0] bz,
	input  wire logic signed [COORD_BITS-1:0] cx,
	input  wire logic signed [COORD_BITS-1:0] cy,
	input  wire logic signed [COORD_BITS-1:0] cz,
	input  wire logic signed [COORD_BITS-1:0] dx,
	input  wire logic signed [COORD_BITS-1:0] dy,
	input  wire logic signed [COORD_BITS-1:0] dz,
	output logic                              done,
	output logic signed [ANGLE_BITS-1:0]      torsion,
	output logic                              degenerate
);

	localparam int DW = COORD_BITS + 1;
	localparam int SHW = $clog2(DW + dafp_pkg::VEC_TOP);
	localparam int WW = DW + dafp_pkg::VEC_TOP;
	localparam int VW = dafp_pkg::VEC_W;
	localparam int TD = dafp_pkg::ISQ_ST - 2;
	localparam int NS = 16 + dafp_pkg::CORDIC_STEPS + 1;
	localparam int RSH = 32 - ANGLE_BITS;

	logic accept;
	logic vld_q [NS];

	assign busy = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= accept;
			for (int i = 1; i < NS; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// stage 1: difference vectors b0 = a-b, b1 = c-b, b2 = d-c
	logic signed [DW-1:0] v_s1 [3][3];

	always_ff @(posedge clk) begin
		v_s1[0][0] <= DW'(ax) - DW'(bx);
		v_s1[0][1] <= DW'(ay) - DW'(by);
		v_s1[0][2] <= DW'(az) - DW'(bz);
		v_s1[1][0] <= DW'(cx) - DW'(bx);
		v_s1[1][1] <= DW'(cy) - DW'(by);
		v_s1[1][2] <= DW'(cz) - DW'(bz);
		v_s1[2][0] <= DW'(dx) - DW'(cx);
		v_s1[2][1] <= DW'(dy) - DW'(cy);
		v_s1[2][2] <= DW'(dz) - DW'(cz);
	end

	// stage 2: sign and magnitude
	logic [DW-1:0] mag_s2 [3][3];
	logic          neg_s2 [3][3];
	logic          dg_s2;

	always_ff @(posedge clk) begin
		for (int v = 0; v < 3; v++) begin
			for (int c = 0; c < 3; c++) begin
				neg_s2[v][c] <= v_s1[v][c][DW-1];
				mag_s2[v][c] <= v_s1[v][c][DW-1] ? DW'(-v_s1[v][c]) : DW'(v_s1[v][c]);
			end
		end
		dg_s2 <= (v_s1[1][0] == '0) && (v_s1[1][1] == '0) && (v_s1[1][2] == '0);
	end

	// stage 3: leading one of the largest component gives the shift
	logic [DW-1:0]  mag_s3 [3][3];
	logic           neg_s3 [3][3];
	logic [SHW-1:0] rs_s3 [3];
	logic [SHW-1:0] ls_s3 [3];
	logic           dg_s3;
	logic [SHW-1:0] rs_c [3];
	logic [SHW-1:0] ls_c [3];

	always_comb begin
		logic [DW-1:0] orv;
		int p;
		for (int v = 0; v < 3; v++) begin
			orv = mag_s2[v][0] | mag_s2[v][1] | mag_s2[v][2];
			p = 0;
			for (int b = 0; b < DW; b++) begin
				if (orv[b]) p = b;
			end
			if (p >= dafp_pkg::VEC_TOP - 1) begin
				rs_c[v] = SHW'(p - (dafp_pkg::VEC_TOP - 1));
				ls_c[v] = '0;
			end else begin
				rs_c[v] = '0;
				ls_c[v] = SHW'((dafp_pkg::VEC_TOP - 1) - p);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		rs_s3 <= rs_c;
		ls_s3 <= ls_c;
		dg_s3 <= dg_s2;
	end

	// stage 4: apply the shift, truncating the magnitude, and put the sign back
	logic signed [VW-1:0] sv_s4 [3][3];
	logic                 dg_s4;

	always_ff @(posedge clk) begin
		logic [WW-1:0] t;
		logic [VW-1:0] a;
		for (int v = 0; v < 3; v++) begin
			for (int c = 0; c < 3; c++) begin
				t = WW'(mag_s3[v][c]);
				t = (rs_s3[v] != '0) ? (t >> rs_s3[v]) : (t << ls_s3[v]);
				a = {1'b0, t[dafp_pkg::VEC_TOP-1:0]};
				sv_s4[v][c] <= neg_s3[v][c] ? -$signed(a) : $signed(a);
			end
		end
		dg_s4 <= dg_s3;
	end

	// stage 5: products of scaled components
	logic signed [dafp_pkg::PROD_W-1:0] p_s5 [18];
	logic signed [VW-1:0]               b2_s5 [3];
	logic                               dg_s5;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			p_s5[c]     <= sv_s4[1][c] * sv_s4[1][c];
			p_s5[3 + c] <= sv_s4[0][c] * sv_s4[2][c];
			p_s5[6 + c] <= sv_s4[0][c] * sv_s4[1][c];
			p_s5[9 + c] <= sv_s4[2][c] * sv_s4[1][c];
		end
		p_s5[12] <= sv_s4[1][1] * sv_s4[0][2];
		p_s5[13] <= sv_s4[1][2] * sv_s4[0][1];
		p_s5[14] <= sv_s4[1][2] * sv_s4[0][0];
		p_s5[15] <= sv_s4[1][0] * sv_s4[0][2];
		p_s5[16] <= sv_s4[1][0] * sv_s4[0][1];
		p_s5[17] <= sv_s4[1][1] * sv_s4[0][0];
		b2_s5 <= sv_s4[2];
		dg_s5 <= dg_s4;
	end

	// stage 6: dot products and cross product
	localparam int SW = dafp_pkg::SUM_W;
	localparam int CW = dafp_pkg::CROSS_W;
	logic signed [SW-1:0] l2_s6, d02_s6, d0b_s6, d2b_s6;
	logic signed [CW-1:0] cr_s6 [3];
	logic signed [VW-1:0] b2_s6 [3];
	logic                 dg_s6;

	always_ff @(posedge clk) begin
		l2_s6 <= SW'(p_s5[0]) + SW'(p_s5[1]) + SW'(p_s5[2]);
		d02_s6 <= SW'(p_s5[3]) + SW'(p_s5[4]) + SW'(p_s5[5]);
		d0b_s6 <= SW'(p_s5[6]) + SW'(p_s5[7]) + SW'(p_s5[8]);
		d2b_s6 <= SW'(p_s5[9]) + SW'(p_s5[10]) + SW'(p_s5[11]);
		cr_s6[0] <= CW'(p_s5[12]) - CW'(p_s5[13]);
		cr_s6[1] <= CW'(p_s5[14]) - CW'(p_s5[15]);
		cr_s6[2] <= CW'(p_s5[16]) - CW'(p_s5[17]);
		b2_s6 <= b2_s5;
		dg_s6 <= dg_s5;
	end

	// stages 7 and 8: triple product and the dot term
	localparam int TPW = CW + VW;
	localparam int TRW = dafp_pkg::TRIP_W;
	localparam int TW = dafp_pkg::TERM_W;
	logic signed [TPW-1:0] tp_s7 [3];
	logic signed [TW-1:0]  l2d_s7, dd_s7;
	logic signed [TRW-1:0] trip_s8;
	logic signed [TW-1:0]  t1_s8;
	logic                  dg_s7, dg_s8;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) tp_s7[c] <= cr_s6[c] * b2_s6[c];
		l2d_s7 <= TW'(l2_s6) * TW'(d02_s6);
		dd_s7 <= TW'(d0b_s6) * TW'(d2b_s6);
		dg_s7 <= dg_s6;
		trip_s8 <= TRW'(tp_s7[0]) + TRW'(tp_s7[1]) + TRW'(tp_s7[2]);
		t1_s8 <= l2d_s7 - dd_s7;
		dg_s8 <= dg_s7;
	end

	// stages 7 to 11: floor square root, three result bits per stage
	localparam int RW = dafp_pkg::REM_W;
	logic [RW-1:0] root_s [dafp_pkg::ISQ_ST];
	logic [RW-1:0] rem_s [dafp_pkg::ISQ_ST];

	for (genvar j = 0; j < dafp_pkg::ISQ_ST; j++) begin : g_isq
		logic [RW-1:0] rt_in, rm_in;
		logic [RW-1:0] rt_c, rm_c;
		if (j == 0) begin : g_first
			assign rt_in = '0;
			assign rm_in = RW'(unsigned'(l2_s6));
		end else begin : g_next
			assign rt_in = root_s[j-1];
			assign rm_in = rem_s[j-1];
		end
		always_comb begin
			logic [RW-1:0] dl;
			int k;
			rt_c = rt_in;
			rm_c = rm_in;
			for (int s = 0; s < dafp_pkg::ISQ_PER; s++) begin
				k = dafp_pkg::ROOT_W - 1 - (dafp_pkg::ISQ_PER * j + s);
				if (k >= 0) begin
					// trying root + 2^k: remainder must cover 2*root*2^k + 4^k
					dl = (rt_c << (k + 1)) + (RW'(1) << (2 * k));
					if (rm_c >= dl) begin
						rm_c = rm_c - dl;
						rt_c = rt_c + (RW'(1) << k);
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			root_s[j] <= rt_c;
			rem_s[j] <= rm_c;
		end
	end

	// delay the triple product and dot term to meet the root
	logic signed [TRW-1:0] trip_d_s [TD];
	logic signed [TW-1:0]  t1_d_s [TD];
	logic                  dg_d_s [TD];

	always_ff @(posedge clk) begin
		trip_d_s[0] <= trip_s8;
		t1_d_s[0] <= t1_s8;
		dg_d_s[0] <= dg_s8;
		for (int i = 1; i < TD; i++) begin
			trip_d_s[i] <= trip_d_s[i-1];
			t1_d_s[i] <= t1_d_s[i-1];
			dg_d_s[i] <= dg_d_s[i-1];
		end
	end

	// stage 12: cross term scaled by the axis length
	logic signed [TW-1:0] t0_s12, t1_s12;
	logic                 dg_s12;

	always_ff @(posedge clk) begin
		logic signed [dafp_pkg::ROOT_W:0] rt;
		rt = $signed({1'b0, root_s[dafp_pkg::ISQ_ST-1][dafp_pkg::ROOT_W-1:0]});
		t0_s12 <= TW'(trip_d_s[TD-1]) * TW'(rt);
		t1_s12 <= t1_d_s[TD-1];
		dg_s12 <= dg_d_s[TD-1];
	end

	// stages 13 to 15: joint term normalise
	localparam int TSW = dafp_pkg::TSH_W;
	logic [TW-1:0]  tm_s13 [2];
	logic           tn_s13 [2];
	logic [TW-1:0]  tor_s13;
	logic           dg_s13;
	logic [TW-1:0]  tm_s14 [2];
	logic           tn_s14 [2];
	logic [TSW-1:0] trs_s14, tls_s14;
	logic           dg_s14;
	logic signed [dafp_pkg::XY_W-1:0] ty_s15, tx_s15;
	logic           dg_s15;

	always_ff @(posedge clk) begin
		tn_s13[0] <= t0_s12[TW-1];
		tn_s13[1] <= t1_s12[TW-1];
		tm_s13[0] <= t0_s12[TW-1] ? unsigned'(-t0_s12) : unsigned'(t0_s12);
		tm_s13[1] <= t1_s12[TW-1] ? unsigned'(-t1_s12) : unsigned'(t1_s12);
		tor_s13 <= (t0_s12[TW-1] ? unsigned'(-t0_s12) : unsigned'(t0_s12))
			| (t1_s12[TW-1] ? unsigned'(-t1_s12) : unsigned'(t1_s12));
		dg_s13 <= dg_s12;
	end

	always_ff @(posedge clk) begin
		int p;
		p = 0;
		for (int b = 0; b < TW; b++) begin
			if (tor_s13[b]) p = b;
		end
		if (p >= dafp_pkg::TERM_TOP - 1) begin
			trs_s14 <= TSW'(p - (dafp_pkg::TERM_TOP - 1));
			tls_s14 <= '0;
		end else begin
			trs_s14 <= '0;
			tls_s14 <= TSW'((dafp_pkg::TERM_TOP - 1) - p);
		end
		tm_s14 <= tm_s13;
		tn_s14 <= tn_s13;
		// both terms zero means the angle is undefined
		dg_s14 <= dg_s13 | (tor_s13 == '0);
	end

	always_ff @(posedge clk) begin
		logic [TW-1:0] t;
		logic signed [dafp_pkg::XY_W-1:0] a [2];
		for (int i = 0; i < 2; i++) begin
			t = (trs_s14 != '0) ? (tm_s14[i] >> trs_s14) : (tm_s14[i] << tls_s14);
			a[i] = $signed(dafp_pkg::XY_W'(t[dafp_pkg::TERM_TOP-1:0]));
			if (tn_s14[i]) a[i] = -a[i];
		end
		ty_s15 <= a[0];
		tx_s15 <= a[1];
		dg_s15 <= dg_s14;
	end

	// stage 16: move x into the right half plane; stages 17 to 46: rotations
	localparam int XW = dafp_pkg::XY_W;
	localparam int ZW = dafp_pkg::Z_W;
	localparam int NC = dafp_pkg::CORDIC_STEPS;
	logic signed [XW-1:0] xc_s [NC+1];
	logic signed [XW-1:0] yc_s [NC+1];
	logic signed [ZW-1:0] zc_s [NC+1];
	logic                 dgc_s [NC+1];

	always_ff @(posedge clk) begin
		if (tx_s15 < 0) begin
			if (ty_s15 >= 0) begin
				yc_s[0] <= -tx_s15;
				xc_s[0] <= ty_s15;
				zc_s[0] <= ZW'(1) <<< 30;
			end else begin
				yc_s[0] <= tx_s15;
				xc_s[0] <= -ty_s15;
				zc_s[0] <= -(ZW'(1) <<< 30);
			end
		end else begin
			yc_s[0] <= ty_s15;
			xc_s[0] <= tx_s15;
			zc_s[0] <= '0;
		end
		dgc_s[0] <= dg_s15;
	end

	for (genvar i = 0; i < NC; i++) begin : g_rot
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] at;
		assign xs = xc_s[i] >>> i;
		assign ys = yc_s[i] >>> i;
		assign at = $signed(ZW'(dafp_pkg::ATAN_TAB[i]));
		always_ff @(posedge clk) begin
			if (yc_s[i] > 0) begin
				xc_s[i+1] <= xc_s[i] + ys;
				yc_s[i+1] <= yc_s[i] - xs;
				zc_s[i+1] <= zc_s[i] + at;
			end else begin
				xc_s[i+1] <= xc_s[i] - ys;
				yc_s[i+1] <= yc_s[i] + xs;
				zc_s[i+1] <= zc_s[i] - at;
			end
			dgc_s[i+1] <= dgc_s[i];
		end
	end

	// stage 47: round half up, saturate, drive the result
	logic signed [ZW-1:0] zr;
	logic signed [ZW-1:0] hi, lo;
	logic signed [ANGLE_BITS-1:0] ang;
	logic signed [ANGLE_BITS-1:0] torsion_q;
	logic degenerate_q;

	assign zr = (zc_s[NC] + (ZW'(1) <<< (RSH - 1))) >>> RSH;
	assign hi = (ZW'(1) <<< (ANGLE_BITS - 1)) - ZW'(1);
	assign lo = -(ZW'(1) <<< (ANGLE_BITS - 1));

	always_comb begin
		priority if (zr > hi) ang = hi[ANGLE_BITS-1:0];
		else if (zr < lo) ang = lo[ANGLE_BITS-1:0];
		else ang = zr[ANGLE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		torsion_q <= dgc_s[NC] ? '0 : ang;
		degenerate_q <= dgc_s[NC];
	end

	assign done = vld_q[NS-1];
	assign torsion = torsion_q;
	assign degenerate = degenerate_q;

`ifndef ASSERT_OFF
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> torsion == '0)
		else $error("degenerate result with nonzero angle");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##NS done)
		else $error("accepted item did not produce a result");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("pipeline refused a transfer");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_dihedral_angle_four_points_top.sv =====
// tb_dihedral_angle_four_points_top: self-checking bench for the torsion angle pipeline
// depends on dihedral_angle_four_points_top (and through it dafp_pkg)
// a bit-exact software predictor feeds a scoreboard that checks each done strobe in order
`timescale 1ns / 1ps

class torsion_scoreboard;
	logic signed [15:0] exp_angle [$];
	bit exp_degen [$];
	int mismatches;
	int checked;
	int degen_seen;

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// power-of-two normalise, magnitude truncated, sign restored
	function automatic void normalise(ref longint v [3], input int n, input int top);
		longint m;
		longint a;
		int rs;
		int ls;
		m = 0;
		rs = 0;
		ls = 0;
		for (int i = 0; i < n; i++)
			if (abs64(v[i]) > m) m = abs64(v[i]);
		if (m == 0)
			return;
		while (m >= (64'sd1 << top)) begin
			m = m >>> 1;
			rs++;
		end
		while (m < (64'sd1 << (top - 1))) begin
			m = m <<< 1;
			ls++;
		end
		for (int i = 0; i < n; i++) begin
			a = abs64(v[i]);
			a = rs != 0 ? (a >>> rs) : (a <<< ls);
			v[i] = v[i] < 0 ? -a : a;
		end
	endfunction

	function automatic longint floor_root(longint x);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > x) b = b >>> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint vector_atan2(longint y, longint x);
		longint z;
		longint t;
		longint xs;
		longint ys;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; z = 64'sd1 <<< 30;
			end else begin
				t = -y; y = x; x = t; z = -(64'sd1 <<< 30);
			end
		end
		for (int i = 0; i < dafp_pkg::CORDIC_STEPS; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += longint'(dafp_pkg::ATAN_TAB[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(dafp_pkg::ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function void note_quad(logic signed [19:0] p [12]);
		longint b0 [3];
		longint b1 [3];
		longint b2 [3];
		longint tm [3];
		longint l2, d02, d0b, d2b, trip, z;
		for (int i = 0; i < 3; i++) begin
			b0[i] = longint'(p[i]) - longint'(p[3 + i]);
			b1[i] = longint'(p[6 + i]) - longint'(p[3 + i]);
			b2[i] = longint'(p[9 + i]) - longint'(p[6 + i]);
		end
		if (b1[0] == 0 && b1[1] == 0 && b1[2] == 0) begin
			exp_angle.push_back(0);
			exp_degen.push_back(1);
			return;
		end
		normalise(b0, 3, 14);
		normalise(b1, 3, 14);
		normalise(b2, 3, 14);
		l2 = b1[0] * b1[0] + b1[1] * b1[1] + b1[2] * b1[2];
		d02 = b0[0] * b2[0] + b0[1] * b2[1] + b0[2] * b2[2];
		d0b = b0[0] * b1[0] + b0[1] * b1[1] + b0[2] * b1[2];
		d2b = b2[0] * b1[0] + b2[1] * b1[1] + b2[2] * b1[2];
		trip = (b1[1] * b0[2] - b1[2] * b0[1]) * b2[0]
			+ (b1[2] * b0[0] - b1[0] * b0[2]) * b2[1]
			+ (b1[0] * b0[1] - b1[1] * b0[0]) * b2[2];
		tm[0] = trip * floor_root(l2);
		tm[1] = l2 * d02 - d0b * d2b;
		tm[2] = 0;
		normalise(tm, 2, 29);
		if (tm[0] == 0 && tm[1] == 0) begin
			exp_angle.push_back(0);
			exp_degen.push_back(1);
			return;
		end
		z = floor_shift(vector_atan2(tm[0], tm[1]) + (64'sd1 <<< 15), 16);
		if (z > 32767) z = 32767;
		if (z < -32768) z = -32768;
		exp_angle.push_back(16'(z));
		exp_degen.push_back(0);
	endfunction

	function void check_result(logic signed [15:0] angle, logic degen);
		logic signed [15:0] ea;
		bit ed;
		checked++;
		if (exp_angle.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: torsion %0d degenerate %0b", angle, degen);
			return;
		end
		ea = exp_angle.pop_front();
		ed = exp_degen.pop_front();
		if (ed) degen_seen++;
		if (angle !== ea || degen !== ed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %0d: torsion exp %0d got %0d, degenerate exp %0b got %0b",
					checked, ea, angle, ed, degen);
		end
	endfunction
endclass

module tb_dihedral_angle_four_points_top;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [19:0] crd [12];
	logic done;
	logic signed [15:0] torsion;
	logic degenerate;
	torsion_scoreboard sb;
	int sent;

	dihedral_angle_four_points_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ax(crd[0]), .ay(crd[1]), .az(crd[2]), .bx(crd[3]), .by(crd[4]), .bz(crd[5]),
		.cx(crd[6]), .cy(crd[7]), .cz(crd[8]), .dx(crd[9]), .dy(crd[10]), .dz(crd[11]),
		.done(done), .torsion(torsion), .degenerate(degenerate)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("dihedral_angle_four_points_top regression: fail");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(torsion, degenerate);

	// hold start for one transfer, then idle for a random gap that may be zero
	task automatic send_quad(logic signed [19:0] q [12]);
		int gap;
		crd = q;
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_quad(q);
		sent++;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
			: (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
		if (gap != 0) begin
			@(negedge clk);
			start <= 0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
	endtask

	function automatic logic signed [19:0] rand_coord(int mode);
		case (mode)
			0: return 20'($urandom);
			1: return 20'sd524287;
			2: return -20'sd524288;
			default: return 20'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	initial begin
		logic signed [19:0] q [12];
		int mode;
		sb = new();
		arst_n = 0;
		start = 0;
		for (int i = 0; i < 12; i++) crd[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: zero axis, all corners (some collinear), cis, right-angle and pi torsions
		for (int i = 0; i < 12; i++) q[i] = 0;
		send_quad(q);
		for (int i = 0; i < 12; i++) q[i] = 20'sd524287;
		send_quad(q);
		for (int i = 0; i < 12; i++) q[i] = -20'sd524288;
		send_quad(q);
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 12; i++)
				q[i] = ((i + k) % 2) ? 20'sd524287 : -20'sd524288;
			send_quad(q);
		end
		q = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, 0};
		send_quad(q); // cis: the triple product vanishes, angle zero
		q = '{256, 0, 0, 0, 0, 0, 0, 256, 0, -256, 256, 0};
		send_quad(q); // trans, angle of pi saturates
		q = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 256, 256};
		send_quad(q);
		q = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 256, -256};
		send_quad(q);
		q = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, 1};
		send_quad(q);
		q = '{256, 0, 0, 0, 0, 0, 0, 256, 0, 256, 256, -1};
		send_quad(q);
		q = '{-524288, 524287, 0, 524287, -524288, 0, 0, 0, 1, 1, 0, 0};
		send_quad(q);

		// wait for the pipe to drain before the random part
		start <= 0;
		while (sb.exp_angle.size() != 0) @(negedge clk);

		for (int n = 0; n < 1500; n++) begin
			mode = $urandom_range(0, 9);
			for (int i = 0; i < 12; i++)
				q[i] = rand_coord(mode < 5 ? 0 : (mode < 8 ? 3 : $urandom_range(0, 3)));
			if ($urandom_range(0, 19) == 0) q[6 +: 3] = q[3 +: 3];
			if ($urandom_range(0, 29) == 0) q[9 +: 3] = q[0 +: 3];
			send_quad(q);
		end
		start <= 0;
		while (sb.exp_angle.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);

		$display("sent %0d quadruples, checked %0d results, %0d of them degenerate",
			sent, sb.checked, sb.degen_seen);
		if (sb.mismatches == 0 && sb.exp_angle.size() == 0)
			$display("dihedral_angle_four_points_top regression: pass");
		else
			$display("dihedral_angle_four_points_top regression: fail");
		$finish;
	end
endmodule
